FILE: rtl/core/contiguous_region_allocator_macros.svh
// Assertion macros for the region allocator.
`ifndef CONTIGUOUS_REGION_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_REGION_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that the antecedent implies the consequent in the same cycle.
`define CRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the antecedent implies the consequent in the next cycle.
`define CRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/cra_pkg.sv
package cra_pkg;

    localparam int ADDR_BITS  = 32;
    localparam int NAME_BYTES = 5;
    localparam int NAME_W     = 40;
    localparam int SPACE_W    = ADDR_BITS + 1;

    localparam logic [NAME_W-1:0] NAME_MASK =
        NAME_W'((64'(1) << (8 * NAME_BYTES)) - 64'(1));
    localparam logic [SPACE_W-1:0] SPACE_RESET = SPACE_W'(1048576);
    localparam logic [SPACE_W-1:0] SPACE_MAX   = SPACE_W'(1) << ADDR_BITS;

    // Item kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_COMPACT = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    // Fit modes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NO_NAME   = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd5;

    typedef struct packed {
        logic [1:0]        kind;
        logic [NAME_W-1:0] owner_name;
        logic [31:0]       request_size;
        logic [1:0]        fit_mode;
        logic [9:0]        entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [31:0]       region_start;
        logic [31:0]       region_stop;
        logic [NAME_W-1:0] region_owner;
        logic              region_is_hole;
        logic [10:0]       region_count;
    } t_out;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [NAME_W-1:0]    owner;
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] stop;
        logic                 free;
    } t_entry;

    // Verdict of the scan unit on one entry
    typedef struct packed {
        logic [SPACE_W-1:0] len;
        logic               cand;
        logic               match;
    } t_fit;

endpackage

FILE: rtl/core/cra_ram.sv
module cra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cra_fit.sv
module cra_fit (
    input  cra_pkg::t_entry                i_entry,
    input  logic [cra_pkg::SPACE_W-1:0]    i_size,
    input  logic [1:0]                     i_mode,
    input  logic                           i_found,
    input  logic [cra_pkg::SPACE_W-1:0]    i_best,
    input  logic [cra_pkg::NAME_W-1:0]     i_name,
    output cra_pkg::t_fit                  o_fit
);

    logic [cra_pkg::SPACE_W-1:0] len;
    logic                        better;

    // Length of the region and whether it beats the current pick
    always_comb begin
        len = {1'b0, i_entry.stop} - {1'b0, i_entry.start} + cra_pkg::SPACE_W'(1);
        better = !i_found
              || (i_mode == cra_pkg::FIT_BEST  && len < i_best)
              || (i_mode == cra_pkg::FIT_WORST && len > i_best);
        o_fit.len   = len;
        o_fit.cand  = i_entry.free && (len >= i_size) && better;
        o_fit.match = !i_entry.free && (i_entry.owner == i_name);
    end

endmodule

FILE: rtl/core/contiguous_region_allocator.sv
// Contiguous region allocator. The region table lives in one RAM with a
// registered read port and one write port, walked by a small sequencer;
// the block takes one item at a time (o_in_stall is high while it works).
// Per item, N = entries in the table: request and release scan the entries
// in turn, move entries up for the split or down for the merge, then write
// back and hand over; compact walks all N entries, then writes the tail hole;
// read entry reads one entry; an error caught before the scan goes straight
// to the result.
// A result is handed over as soon as the output register is free, and the
// next transaction is taken while it waits there. After reset and after
// each space_size write the table is rebuilt as one hole before new items
// are taken.
`include "contiguous_region_allocator_macros.svh"

module contiguous_region_allocator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cra_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cra_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [cra_pkg::SPACE_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = cra_pkg::SPACE_W;
    localparam int AB = cra_pkg::ADDR_BITS;
    localparam int NW = cra_pkg::NAME_W;

    localparam logic [4:0] S_INIT     = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_RQ_RD    = 5'd2;
    localparam logic [4:0] S_RQ_EV    = 5'd3;
    localparam logic [4:0] S_SH_RD    = 5'd4;
    localparam logic [4:0] S_SH_WR    = 5'd5;
    localparam logic [4:0] S_RQ_W0    = 5'd6;
    localparam logic [4:0] S_RQ_W1    = 5'd7;
    localparam logic [4:0] S_RL_RD    = 5'd8;
    localparam logic [4:0] S_RL_EV    = 5'd9;
    localparam logic [4:0] S_RL_NX_RD = 5'd10;
    localparam logic [4:0] S_RL_NX_EV = 5'd11;
    localparam logic [4:0] S_RL_FIX   = 5'd12;
    localparam logic [4:0] S_DR_RD    = 5'd13;
    localparam logic [4:0] S_DR_WR    = 5'd14;
    localparam logic [4:0] S_CP_RD    = 5'd15;
    localparam logic [4:0] S_CP_EV    = 5'd16;
    localparam logic [4:0] S_CP_TAIL  = 5'd17;
    localparam logic [4:0] S_RD_RD    = 5'd18;
    localparam logic [4:0] S_RD_EV    = 5'd19;
    localparam logic [4:0] S_DONE     = 5'd20;

    logic [4:0]        r_state, n_state;
    logic [CW-1:0]     r_cnt,   n_cnt;
    logic [CW-1:0]     r_i,     n_i;
    logic [CW-1:0]     r_n,     n_n;
    logic [CW-1:0]     r_pick,  n_pick;
    logic [1:0]        r_dd,    n_dd;
    logic [SW-1:0]     r_space, n_space;
    logic [SW-1:0]     r_best,  n_best;
    logic [SW-1:0]     r_pos,   n_pos;
    logic              r_found, n_found;
    logic              r_nxf,   n_nxf;
    logic [NW-1:0]     r_name,  n_name;
    logic [SW-1:0]     r_size,  n_size;
    logic [1:0]        r_mode,  n_mode;
    logic [9:0]        r_idx,   n_idx;
    cra_pkg::t_entry   r_pe,    n_pe;
    cra_pkg::t_entry   r_prev,  n_prev;
    cra_pkg::t_entry   r_nx,    n_nx;
    logic [2:0]        r_st,    n_st;
    logic [AB-1:0]     r_a,     n_a;
    logic [AB-1:0]     r_b,     n_b;
    logic [NW-1:0]     r_own,   n_own;
    logic              r_hole,  n_hole;
    logic              r_out_valid, n_out_valid;
    cra_pkg::t_out     r_out,   n_out;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    cra_pkg::t_entry   ram_wdata;
    cra_pkg::t_entry   ram_q;
    cra_pkg::t_fit     fit;

    cra_ram #(
        .WIDTH ($bits(cra_pkg::t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    cra_fit u_fit (
        .i_entry (ram_q),
        .i_size  (r_size),
        .i_mode  (r_mode),
        .i_found (r_found),
        .i_best  (r_best),
        .i_name  (r_name),
        .o_fit   (fit)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer
    always_comb begin
        logic [SW-1:0] cfg_v;
        logic [AB-1:0] hstop;
        logic [AB-1:0] clen;
        logic          last;
        logic          pf;

        n_state = r_state;  n_cnt  = r_cnt;   n_i    = r_i;     n_n    = r_n;
        n_pick  = r_pick;   n_dd   = r_dd;    n_space = r_space; n_best = r_best;
        n_pos   = r_pos;    n_found = r_found; n_nxf = r_nxf;   n_name = r_name;
        n_size  = r_size;   n_mode = r_mode;  n_idx  = r_idx;   n_pe   = r_pe;
        n_prev  = r_prev;   n_nx   = r_nx;    n_st   = r_st;    n_a    = r_a;
        n_b     = r_b;      n_own  = r_own;   n_hole = r_hole;
        n_out   = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        ram_we    = 1'b0;
        ram_waddr = AW'(r_i);
        ram_raddr = AW'(r_i);
        ram_wdata = '0;

        hstop = r_pe.stop;
        clen  = ram_q.stop - ram_q.start;
        last  = ({1'b0, r_i} + (CW+1)'(1)) >= {1'b0, r_cnt};
        pf    = (r_pick != '0) && r_prev.free;
        cfg_v = i_cfg_data;
        if (cfg_v == '0) begin
            cfg_v = SW'(1);
        end else if (cfg_v > cra_pkg::SPACE_MAX) begin
            cfg_v = cra_pkg::SPACE_MAX;
        end

        case (r_state)
            // Rebuild the table as one hole
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{owner: '0, start: '0, stop: AB'(r_space - SW'(1)), free: 1'b1};
                n_cnt     = CW'(1);
                n_state   = S_IDLE;
            end
            // Take a transaction and screen it
            S_IDLE: begin
                if (i_in_valid) begin
                    n_name  = i_in_data.owner_name & cra_pkg::NAME_MASK;
                    n_size  = SW'(i_in_data.request_size);
                    n_mode  = i_in_data.fit_mode;
                    n_idx   = i_in_data.entry_index;
                    n_i     = '0;
                    n_n     = '0;
                    n_pos   = '0;
                    n_found = 1'b0;
                    n_best  = '0;
                    n_st    = cra_pkg::ST_OK;
                    n_a     = '0;
                    n_b     = '0;
                    n_own   = '0;
                    n_hole  = 1'b0;
                    case (i_in_data.kind)
                        cra_pkg::KIND_REQUEST: begin
                            if (i_in_data.request_size == '0) begin
                                n_st = cra_pkg::ST_BAD_SIZE;  n_state = S_DONE;
                            end else if (r_cnt >= CW'(TABLE_DEPTH)) begin
                                n_st = cra_pkg::ST_FULL;      n_state = S_DONE;
                            end else if (i_in_data.fit_mode inside {cra_pkg::FIT_FIRST,
                                         cra_pkg::FIT_BEST, cra_pkg::FIT_WORST}) begin
                                n_state = S_RQ_RD;
                            end else begin
                                n_st = cra_pkg::ST_NO_FIT;    n_state = S_DONE;
                            end
                        end
                        cra_pkg::KIND_RELEASE: n_state = S_RL_RD;
                        cra_pkg::KIND_COMPACT: n_state = S_CP_RD;
                        default: begin
                            if (32'(i_in_data.entry_index) >= 32'(r_cnt)) begin
                                n_st = cra_pkg::ST_BAD_INDEX; n_state = S_DONE;
                            end else begin
                                n_state = S_RD_RD;
                            end
                        end
                    endcase
                end
            end
            // Scan holes for the fit
            S_RQ_RD: begin
                n_state = S_RQ_EV;
            end
            S_RQ_EV: begin
                n_i     = r_i + CW'(1);
                n_state = S_RQ_RD;
                if (fit.cand) begin
                    n_found = 1'b1;
                    n_pick  = r_i;
                    n_best  = fit.len;
                    n_pe    = ram_q;
                end
                if ((fit.cand && r_mode == cra_pkg::FIT_FIRST) || last) begin
                    if (!n_found) begin
                        n_st    = cra_pkg::ST_NO_FIT;
                        n_state = S_DONE;
                    end else if (n_best == r_size) begin
                        n_state = S_RQ_W0;
                    end else begin
                        n_i     = r_cnt;
                        n_state = S_SH_RD;
                    end
                end
            end
            // Open a slot after the pick by moving entries up
            S_SH_RD: begin
                ram_raddr = AW'(r_i - CW'(1));
                if ({1'b0, r_i} > ({1'b0, r_pick} + (CW+1)'(1))) begin
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_RQ_W0;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_i);
                ram_wdata = ram_q;
                n_i       = r_i - CW'(1);
                n_state   = S_SH_RD;
            end
            // Place the region at the top of the hole
            S_RQ_W0: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_pick);
                n_st      = cra_pkg::ST_OK;
                n_a       = AB'({1'b0, hstop} - r_size + SW'(1));
                n_b       = hstop;
                n_own     = r_name;
                n_hole    = 1'b0;
                if (r_best == r_size) begin
                    ram_wdata = '{owner: r_name, start: r_pe.start, stop: r_pe.stop,
                                  free: 1'b0};
                    n_state   = S_DONE;
                end else begin
                    ram_wdata = '{owner: r_pe.owner, start: r_pe.start,
                                  stop: AB'({1'b0, hstop} - r_size), free: 1'b1};
                    n_state   = S_RQ_W1;
                end
            end
            S_RQ_W1: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_pick + CW'(1));
                ram_wdata = '{owner: r_name, start: r_a, stop: r_b, free: 1'b0};
                n_cnt     = r_cnt + CW'(1);
                n_state   = S_DONE;
            end
            // Find the first region owned by the name
            S_RL_RD: begin
                n_state = S_RL_EV;
            end
            S_RL_EV: begin
                if (fit.match) begin
                    n_pe   = ram_q;
                    n_pick = r_i;
                    n_nxf  = 1'b0;
                    if (last) begin
                        n_state = S_RL_FIX;
                    end else begin
                        n_state = S_RL_NX_RD;
                    end
                end else begin
                    n_prev = ram_q;
                    n_i    = r_i + CW'(1);
                    if (last) begin
                        n_st    = cra_pkg::ST_NO_NAME;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_RL_RD;
                    end
                end
            end
            S_RL_NX_RD: begin
                ram_raddr = AW'(r_pick + CW'(1));
                n_state   = S_RL_NX_EV;
            end
            S_RL_NX_EV: begin
                n_nx    = ram_q;
                n_nxf   = ram_q.free;
                n_state = S_RL_FIX;
            end
            // Free the region and merge with holes on both sides
            S_RL_FIX: begin
                ram_we  = 1'b1;
                n_st    = cra_pkg::ST_OK;
                n_a     = r_pe.start;
                n_b     = r_pe.stop;
                n_own   = r_name;
                n_hole  = 1'b1;
                n_state = S_DR_RD;
                if (!pf) begin
                    ram_waddr = AW'(r_pick);
                    ram_wdata = '{owner: '0, start: r_pe.start,
                                  stop: r_nxf ? r_nx.stop : r_pe.stop, free: 1'b1};
                    n_i       = r_pick + CW'(1);
                    n_dd      = 2'd1;
                    if (!r_nxf) begin
                        n_state = S_DONE;
                    end
                end else begin
                    ram_waddr = AW'(r_pick - CW'(1));
                    ram_wdata = '{owner: '0, start: r_prev.start,
                                  stop: r_nxf ? r_nx.stop : r_pe.stop, free: 1'b1};
                    n_i       = r_pick;
                    n_dd      = r_nxf ? 2'd2 : 2'd1;
                end
            end
            // Close the gap by moving entries down
            S_DR_RD: begin
                ram_raddr = AW'(r_i + CW'(r_dd));
                if (({1'b0, r_i} + (CW+1)'(r_dd)) < {1'b0, r_cnt}) begin
                    n_state = S_DR_WR;
                end else begin
                    n_cnt   = r_cnt - CW'(r_dd);
                    n_state = S_DONE;
                end
            end
            S_DR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_i);
                ram_wdata = ram_q;
                n_i       = r_i + CW'(1);
                n_state   = S_DR_RD;
            end
            // Pack owned regions from address zero
            S_CP_RD: begin
                if (r_i < r_cnt) begin
                    n_state = S_CP_EV;
                end else begin
                    n_state = S_CP_TAIL;
                end
            end
            S_CP_EV: begin
                if (!ram_q.free) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_n);
                    ram_wdata = '{owner: ram_q.owner, start: AB'(r_pos),
                                  stop: AB'(r_pos + SW'(clen)), free: 1'b0};
                    n_pos     = r_pos + SW'(clen) + SW'(1);
                    n_n       = r_n + CW'(1);
                end
                n_i     = r_i + CW'(1);
                n_state = S_CP_RD;
            end
            S_CP_TAIL: begin
                n_st = cra_pkg::ST_OK;
                if (r_pos < r_space && r_n < CW'(TABLE_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_n);
                    ram_wdata = '{owner: '0, start: AB'(r_pos),
                                  stop: AB'(r_space - SW'(1)), free: 1'b1};
                    n_cnt     = r_n + CW'(1);
                    n_a       = AB'(r_pos);
                    n_b       = AB'(r_space - SW'(1));
                    n_hole    = 1'b1;
                end else begin
                    n_cnt     = r_n;
                end
                n_state = S_DONE;
            end
            // Read one entry
            S_RD_RD: begin
                ram_raddr = AW'(r_idx);
                n_state   = S_RD_EV;
            end
            S_RD_EV: begin
                n_st    = cra_pkg::ST_OK;
                n_a     = ram_q.start;
                n_b     = ram_q.stop;
                n_own   = ram_q.free ? '0 : ram_q.owner;
                n_hole  = ram_q.free;
                n_state = S_DONE;
            end
            // Hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status         = r_st;
                    n_out.region_start   = 32'(r_a);
                    n_out.region_stop    = 32'(r_b);
                    n_out.region_owner   = r_own;
                    n_out.region_is_hole = r_hole;
                    n_out.region_count   = 11'(r_cnt);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // Register write resets the table
        if (i_cfg_we) begin
            n_space = cfg_v;
            n_state = S_INIT;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_space     <= cra_pkg::SPACE_RESET;
            r_cnt       <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_space     <= n_space;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;     r_n    <= n_n;    r_pick <= n_pick; r_dd   <= n_dd;
        r_best  <= n_best;  r_pos  <= n_pos;  r_found <= n_found; r_nxf <= n_nxf;
        r_name  <= n_name;  r_size <= n_size; r_mode <= n_mode; r_idx  <= n_idx;
        r_pe    <= n_pe;    r_prev <= n_prev; r_nx   <= n_nx;   r_st   <= n_st;
        r_a     <= n_a;     r_b    <= n_b;    r_own  <= n_own;  r_hole <= n_hole;
        r_out   <= n_out;
    end

    `CRA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= CW'(TABLE_DEPTH), "table count beyond depth")
    `CRA_ASSERT_NXT(a_split_grows, i_clk, i_rst_n, r_state == S_RQ_W1,
        r_cnt == $past(r_cnt) + CW'(1), "split did not add one entry")
    `CRA_ASSERT_IMP(a_drop_inside, i_clk, i_rst_n, r_state == S_DR_WR,
        ({1'b0, r_i} + (CW+1)'(r_dd)) <= {1'b0, r_cnt}, "merge shift outside table")
    `CRA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.status != cra_pkg::ST_OK,
        o_out_data.region_start == '0 && o_out_data.region_is_hole == 1'b0,
        "error result carries region data")

endmodule

FILE: test/contiguous_region_allocator_checker.sv
module contiguous_region_allocator_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  cra_pkg::t_in                i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  cra_pkg::t_out               i_out_data,
    input  logic                        i_cfg_we,
    input  logic [cra_pkg::SPACE_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int SW    = cra_pkg::SPACE_W;
    localparam int AB    = cra_pkg::ADDR_BITS;
    localparam int NW    = cra_pkg::NAME_W;

    // Shadow copy of the region table
    logic [SW-1:0] space_size;
    logic [NW-1:0] tbl_owner [DEPTH];
    logic [AB-1:0] tbl_start [DEPTH];
    logic [AB-1:0] tbl_stop  [DEPTH];
    logic          tbl_free  [DEPTH];
    int            tbl_count;

    cra_pkg::t_out region_results_q [$];

    // Rebuild the table as one hole over the whole space
    task automatic clear_table();
        for (int k = 0; k < DEPTH; k++) begin
            tbl_owner[k] = '0;
            tbl_start[k] = '0;
            tbl_stop[k]  = '0;
            tbl_free[k]  = 1'b0;
        end
        tbl_stop[0] = AB'(space_size - SW'(1));
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
    endtask

    task automatic move_entry(int dst, int src);
        tbl_owner[dst] = tbl_owner[src];
        tbl_start[dst] = tbl_start[src];
        tbl_stop[dst]  = tbl_stop[src];
        tbl_free[dst]  = tbl_free[src];
    endtask

    task automatic remove_entry(int pos);
        for (int k = pos; k + 1 < tbl_count; k++) move_entry(k, k + 1);
        tbl_count--;
    endtask

    // Work out the result of one transaction and update the table
    task automatic place_or_free(input cra_pkg::t_in item, output cra_pkg::t_out res);
        logic [SW-1:0] len;
        logic [SW-1:0] pick_len;
        logic [SW-1:0] pos;
        logic [SW-1:0] size;
        logic [AB-1:0] hstop;
        logic [NW-1:0] name;
        int            pick;
        int            n;
        bit            found;
        res      = '0;
        name     = item.owner_name & cra_pkg::NAME_MASK;
        size     = SW'(item.request_size);
        found    = 1'b0;
        pick     = 0;
        pick_len = '0;
        case (item.kind)
            cra_pkg::KIND_REQUEST: begin
                if (size == '0) begin
                    res.status = cra_pkg::ST_BAD_SIZE;
                end else if (tbl_count >= DEPTH) begin
                    res.status = cra_pkg::ST_FULL;
                end else begin
                    // Search holes; ties keep the earliest
                    if (item.fit_mode inside {cra_pkg::FIT_FIRST, cra_pkg::FIT_BEST,
                                              cra_pkg::FIT_WORST}) begin
                        for (int i = 0; i < tbl_count; i++) begin
                            if (!tbl_free[i]) continue;
                            len = SW'(tbl_stop[i]) - SW'(tbl_start[i]) + SW'(1);
                            if (len < size) continue;
                            if (!found
                                    || (item.fit_mode == cra_pkg::FIT_BEST && len < pick_len)
                                    || (item.fit_mode == cra_pkg::FIT_WORST
                                        && len > pick_len)) begin
                                found    = 1'b1;
                                pick     = i;
                                pick_len = len;
                                if (item.fit_mode == cra_pkg::FIT_FIRST) break;
                            end
                        end
                    end
                    if (!found) begin
                        res.status = cra_pkg::ST_NO_FIT;
                    end else begin
                        hstop = tbl_stop[pick];
                        if (pick_len == size) begin
                            tbl_free[pick]  = 1'b0;
                            tbl_owner[pick] = name;
                        end else begin
                            // Split: hole keeps the bottom, region takes the top
                            for (int i = tbl_count; i > pick + 1; i--) move_entry(i, i - 1);
                            tbl_stop[pick]      = hstop - item.request_size;
                            tbl_start[pick + 1] = hstop - item.request_size + AB'(1);
                            tbl_stop[pick + 1]  = hstop;
                            tbl_free[pick + 1]  = 1'b0;
                            tbl_owner[pick + 1] = name;
                            tbl_count++;
                        end
                        res.status       = cra_pkg::ST_OK;
                        res.region_start = hstop - item.request_size + AB'(1);
                        res.region_stop  = hstop;
                        res.region_owner = name;
                    end
                end
            end
            cra_pkg::KIND_RELEASE: begin
                n = tbl_count;
                for (int i = 0; i < tbl_count; i++) begin
                    if (!tbl_free[i] && tbl_owner[i] == name) begin
                        n = i;
                        break;
                    end
                end
                if (n >= tbl_count) begin
                    res.status = cra_pkg::ST_NO_NAME;
                end else begin
                    res.status         = cra_pkg::ST_OK;
                    res.region_start   = tbl_start[n];
                    res.region_stop    = tbl_stop[n];
                    res.region_owner   = name;
                    res.region_is_hole = 1'b1;
                    tbl_free[n]  = 1'b1;
                    tbl_owner[n] = '0;
                    // Merge with the hole above, then the hole below
                    if (n + 1 < tbl_count && tbl_free[n + 1]) begin
                        tbl_stop[n] = tbl_stop[n + 1];
                        remove_entry(n + 1);
                    end
                    if (n > 0 && tbl_free[n - 1]) begin
                        tbl_stop[n - 1] = tbl_stop[n];
                        remove_entry(n);
                    end
                end
            end
            cra_pkg::KIND_COMPACT: begin
                n   = 0;
                pos = '0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_free[i]) continue;
                    len = SW'(tbl_stop[i] - tbl_start[i]);
                    tbl_owner[n] = tbl_owner[i];
                    tbl_start[n] = AB'(pos);
                    tbl_stop[n]  = AB'(pos + len);
                    tbl_free[n]  = 1'b0;
                    pos = pos + len + SW'(1);
                    n++;
                end
                res.status = cra_pkg::ST_OK;
                if (pos < space_size && n < DEPTH) begin
                    tbl_owner[n] = '0;
                    tbl_start[n] = AB'(pos);
                    tbl_stop[n]  = AB'(space_size - SW'(1));
                    tbl_free[n]  = 1'b1;
                    tbl_count    = n + 1;
                    res.region_start   = AB'(pos);
                    res.region_stop    = AB'(space_size - SW'(1));
                    res.region_is_hole = 1'b1;
                end else begin
                    tbl_count = n;
                end
            end
            default: begin
                if (int'(item.entry_index) >= tbl_count) begin
                    res.status = cra_pkg::ST_BAD_INDEX;
                end else begin
                    n = int'(item.entry_index);
                    res.status         = cra_pkg::ST_OK;
                    res.region_start   = tbl_start[n];
                    res.region_stop    = tbl_stop[n];
                    res.region_owner   = tbl_free[n] ? '0 : tbl_owner[n];
                    res.region_is_hole = tbl_free[n];
                end
            end
        endcase
        res.region_count = 11'(tbl_count);
    endtask

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        space_size     = cra_pkg::SPACE_RESET;
        clear_table();
    end

    // Track configuration, predict accepted transactions, compare results
    always @(posedge i_clk) begin
        cra_pkg::t_out want;
        cra_pkg::t_out got;
        if (!i_rst_n) begin
            space_size = cra_pkg::SPACE_RESET;
            clear_table();
            region_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                space_size = (i_cfg_data == '0) ? SW'(1) :
                             (i_cfg_data > cra_pkg::SPACE_MAX) ? cra_pkg::SPACE_MAX
                                                               : i_cfg_data;
                clear_table();
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                o_result_count++;
                if (region_results_q.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = region_results_q.pop_front();
                    if (got.status !== want.status || got.region_start !== want.region_start
                            || got.region_stop !== want.region_stop
                            || got.region_owner !== want.region_owner
                            || got.region_is_hole !== want.region_is_hole
                            || got.region_count !== want.region_count) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                place_or_free(i_in_data, want);
                region_results_q.push_back(want);
            end
        end
        o_pending = region_results_q.size();
    end

endmodule

FILE: test/tb_contiguous_region_allocator.sv
module tb_contiguous_region_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 30_000_000;
    localparam int     SW          = cra_pkg::SPACE_W;
    localparam int     NW          = cra_pkg::NAME_W;
    localparam int     HOLD_LEN    = 400;
    // Fit mode with no meaning; it never finds a hole
    localparam logic [1:0] FIT_NONE = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    cra_pkg::t_in        in_data;
    logic                out_valid;
    logic                out_stall;
    cra_pkg::t_out       out_data;
    logic                cfg_we;
    logic [SW-1:0]       cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_req;
    int sent_count;
    int cfg_count;
    logic [SW-1:0] cur_space;

    contiguous_region_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    contiguous_region_allocator_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold when asked
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Hard stop on a hung run
    initial begin
        for (longint c = 0; c < CYCLE_LIMIT; c++) @(posedge i_clk);
        $display("contiguous_region_allocator verification failed");
        $finish;
    end

    // Offer one transaction and hold it until accepted
    task automatic send_item(input cra_pkg::t_in item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        // Stall comes from a register, so its value here holds at the next edge
        while (in_stall) @(negedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    // Drain all results, then write the space size
    task automatic write_space(input logic [SW-1:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_data  = value;
        cur_space = (value == '0) ? SW'(1) :
                    (value > cra_pkg::SPACE_MAX) ? cra_pkg::SPACE_MAX : value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        cfg_count++;
    endtask

    function automatic cra_pkg::t_in make_item(logic [1:0] kind, logic [31:0] size,
                                               logic [1:0] fit, logic [NW-1:0] name,
                                               logic [9:0] idx);
        cra_pkg::t_in item;
        item.kind         = kind;
        item.request_size = size;
        item.fit_mode     = fit;
        item.owner_name   = name;
        item.entry_index  = idx;
        return item;
    endfunction

    function automatic logic [NW-1:0] pool_name();
        return NW'(40'h5245_4700 + $urandom_range(1, 8));
    endfunction

    // Mostly well-formed traffic over a small name pool, with some noise
    function automatic cra_pkg::t_in random_item();
        cra_pkg::t_in item;
        logic [95:0]  raw;
        int           pick;
        longint       span;
        raw  = {$urandom, $urandom, $urandom};
        item = raw[$bits(cra_pkg::t_in)-1:0];
        pick = $urandom_range(0, 99);
        span = (cur_space / 6 > 1) ? cur_space / 6 : 1;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        if (pick < 50) begin
            item.kind = cra_pkg::KIND_REQUEST;
            item.fit_mode = ($urandom_range(0, 99) < 4) ? FIT_NONE
                                                        : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) != 0)
                item.request_size = $urandom_range(1, 32'(span));
            if ($urandom_range(0, 9) != 0) item.owner_name = pool_name();
        end else if (pick < 78) begin
            item.kind = cra_pkg::KIND_RELEASE;
            if ($urandom_range(0, 9) != 0) item.owner_name = pool_name();
        end else if (pick < 94) begin
            item.kind = cra_pkg::KIND_READ;
            if ($urandom_range(0, 4) != 0) item.entry_index = 10'($urandom_range(0, 30));
        end else begin
            item.kind = cra_pkg::KIND_COMPACT;
        end
        return item;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        tx_idle_pct = 16;
        rx_idle_pct = 73;
        hold_req    = 0;
        sent_count  = 0;
        cfg_count   = 0;
        cur_space   = cra_pkg::SPACE_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: errors, each fit mode, release merge, compact, reads
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd0, cra_pkg::FIT_FIRST, 40'h41, 10'd0));
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd16, FIT_NONE, 40'h41, 10'd0));
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'hFFFF_FFFF, cra_pkg::FIT_FIRST,
                            40'h41, 10'd0));
        send_item(make_item(cra_pkg::KIND_READ, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd1023));
        send_item(make_item(cra_pkg::KIND_READ, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd0));
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd100, cra_pkg::FIT_FIRST,
                            40'hFF_FFFF_FFFF, 10'd0));
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd200, cra_pkg::FIT_BEST, 40'h42, 10'd0));
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd300, cra_pkg::FIT_WORST, 40'h42, 10'd0));
        send_item(make_item(cra_pkg::KIND_RELEASE, 32'd0, cra_pkg::FIT_FIRST, 40'h99, 10'd0));
        send_item(make_item(cra_pkg::KIND_RELEASE, 32'd0, cra_pkg::FIT_FIRST, 40'h42, 10'd0));
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd50, cra_pkg::FIT_BEST, 40'h43, 10'd0));
        send_item(make_item(cra_pkg::KIND_RELEASE, 32'd0, cra_pkg::FIT_FIRST,
                            40'hFF_FFFF_FFFF, 10'd0));
        send_item(make_item(cra_pkg::KIND_COMPACT, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd0));
        send_item(make_item(cra_pkg::KIND_READ, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd1));

        // Zero space acts as one address; exact fit leaves no trailing hole
        write_space('0);
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'd1, cra_pkg::FIT_WORST, 40'h44, 10'd0));
        send_item(make_item(cra_pkg::KIND_COMPACT, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd0));
        send_item(make_item(cra_pkg::KIND_READ, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd0));

        // Largest space, and a value above it that saturates
        write_space(cra_pkg::SPACE_MAX);
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'hFFFF_FFFF, cra_pkg::FIT_BEST,
                            40'h45, 10'd0));
        send_item(make_item(cra_pkg::KIND_READ, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd1));
        write_space({SW{1'b1}});
        send_item(make_item(cra_pkg::KIND_REQUEST, 32'hFFFF_FFFF, cra_pkg::FIT_FIRST,
                            40'h46, 10'd0));
        send_item(make_item(cra_pkg::KIND_COMPACT, 32'd0, cra_pkg::FIT_FIRST, 40'h0, 10'd0));

        // Random phases: sender light and receiver heavy, then swapped, then none
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 73 : 0;
            rx_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 16 : 0;
            write_space(($urandom_range(0, 3) == 0) ? SW'({$urandom, 1'b1})
                                                    : SW'($urandom_range(16, 4096)));
            if (phase == 2) hold_req++;
            for (int k = 0; k < 90; k++) begin
                send_item(random_item());
                if (k == 45) write_space(SW'($urandom_range(8, 512)));
            end
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Sent %0d transactions over %0d space settings, %0d results checked.",
                 sent_count, cfg_count, result_count);
        $display("Covered errors, all fit modes, merges, compaction and long output holds.");
        if (fail_count == 0) begin
            $display("contiguous_region_allocator verification clean");
        end else begin
            $display("contiguous_region_allocator verification failed");
        end
        $finish;
    end

endmodule
